// ===== rtl/eulbv_pkg.sv =====
// ----------------------------------------------------------------------------
// eulbv_pkg
// Types, constants and arithmetic helpers for the Euler-to-basis pipeline.
// ----------------------------------------------------------------------------
package eulbv_pkg;

  localparam int RESULT_WIDTH = 16;
  localparam int AW = 32;
  localparam int QW = 36;
  localparam int MAX_STAGES = 30;

  localparam logic signed [18:0] FULL_TURN = 19'sd23040;
  localparam logic signed [18:0] HALF_TURN = 19'sd11520;
  localparam logic signed [AW-1:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [QW-1:0] ONE_Q30 = 36'sd1073741824;

  typedef logic signed [AW-1:0] val_t;
  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [RESULT_WIDTH-1:0] res_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } angle_word_t;

  typedef struct packed {
    res_t forward_x;
    res_t forward_y;
    res_t forward_z;
    res_t up_x;
    res_t up_y;
    res_t up_z;
    res_t right_x;
    res_t right_y;
    res_t right_z;
  } basis_word_t;

  function automatic val_t atan_deg(input logic [4:0] idx);
    val_t r;
    case (idx)
      5'd0: r = 32'sd188743680;
      5'd1: r = 32'sd111421900;
      5'd2: r = 32'sd58872272;
      5'd3: r = 32'sd29884485;
      5'd4: r = 32'sd15000234;
      5'd5: r = 32'sd7507429;
      5'd6: r = 32'sd3754631;
      5'd7: r = 32'sd1877430;
      5'd8: r = 32'sd938729;
      5'd9: r = 32'sd469366;
      5'd10: r = 32'sd234683;
      5'd11: r = 32'sd117342;
      5'd12: r = 32'sd58671;
      5'd13: r = 32'sd29335;
      5'd14: r = 32'sd14668;
      5'd15: r = 32'sd7334;
      5'd16: r = 32'sd3667;
      5'd17: r = 32'sd1833;
      5'd18: r = 32'sd917;
      5'd19: r = 32'sd458;
      5'd20: r = 32'sd229;
      5'd21: r = 32'sd115;
      5'd22: r = 32'sd57;
      5'd23: r = 32'sd29;
      5'd24: r = 32'sd14;
      5'd25: r = 32'sd7;
      5'd26: r = 32'sd4;
      5'd27: r = 32'sd2;
      5'd28: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [2*QW-1:0] p;
    logic signed [2*QW-1:0] s;
    p = a * b;
    s = (p + (72'sd1 <<< 29)) >>> 30;
    return s[QW-1:0];
  endfunction

  localparam int SH = 32 - RESULT_WIDTH;
  localparam int SHR = (SH > 0) ? SH - 1 : 0;

  function automatic res_t to_out(input q_t v);
    q_t r;
    q_t hi;
    q_t lo;
    hi = (q_t'(1) <<< (RESULT_WIDTH - 1)) - q_t'(1);
    lo = -hi - q_t'(1);
    if (SH > 0) begin
      r = (v + (q_t'(1) <<< SHR)) >>> SH;
    end else begin
      r = v;
    end
    if (r > hi) begin
      r = hi;
    end
    if (r < lo) begin
      r = lo;
    end
    return r[RESULT_WIDTH-1:0];
  endfunction

endpackage

// ===== rtl/eulbv_reduce.sv =====
// ----------------------------------------------------------------------------
// eulbv_reduce
// Half-angle reduction of the three input angles into CORDIC start values.
// ----------------------------------------------------------------------------
module eulbv_reduce (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_vld,
  input  eulbv_pkg::angle_word_t    angles,
  output logic                      out_vld,
  output eulbv_pkg::val_t           z [3],
  output logic                      flip [3]
);
  import eulbv_pkg::*;

  logic signed [15:0] a [3];
  val_t z_next [3];
  logic flip_next [3];

  assign a[0] = angles.roll_angle;
  assign a[1] = angles.pitch_angle;
  assign a[2] = angles.yaw_angle;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [18:0] t;
      logic signed [18:0] r;
      t = 19'(a[k]) + 19'sd69120;
      if (t >= 19'sd92160) begin
        r = t - 19'sd92160;
      end else if (t >= 19'sd69120) begin
        r = t - 19'sd69120;
      end else if (t >= 19'sd46080) begin
        r = t - 19'sd46080;
      end else begin
        r = t - FULL_TURN;
      end
      flip_next[k] = (r >= HALF_TURN);
      if (flip_next[k]) begin
        r = r - FULL_TURN;
      end
      z_next[k] = AW'(r) <<< 15;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z <= z_next;
      flip <= flip_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

endmodule

// ===== rtl/eulbv_cordic.sv =====
// ----------------------------------------------------------------------------
// eulbv_cordic
// Unrolled rotation-mode CORDIC, one register stage per iteration.
// ----------------------------------------------------------------------------
module eulbv_cordic #(
  parameter int STAGES = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  eulbv_pkg::val_t z_in,
  input  logic            flip_in,
  output logic            out_vld,
  output eulbv_pkg::val_t cos_out,
  output eulbv_pkg::val_t sin_out
);
  import eulbv_pkg::*;

  localparam int N = (STAGES > MAX_STAGES) ? MAX_STAGES : STAGES;

  val_t x [N+1];
  val_t y [N+1];
  val_t z [N+1];
  logic flip [N+1];
  logic vld [N+1];

  assign x[0] = CORDIC_GAIN;
  assign y[0] = '0;
  assign z[0] = z_in;
  assign flip[0] = flip_in;
  assign vld[0] = in_vld;

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        flip[i+1] <= flip[i];
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_deg(5'(i));
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_deg(5'(i));
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_out <= flip[N] ? -x[N] : x[N];
      sin_out <= flip[N] ? -y[N] : y[N];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld[N];
    end
  end

  logic unused_z;
  assign unused_z = ^z[N];

endmodule

// ===== rtl/eulbv_quat.sv =====
// ----------------------------------------------------------------------------
// eulbv_quat
// Quaternion from half-angle sines and cosines, three register stages.
// ----------------------------------------------------------------------------
module eulbv_quat (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  eulbv_pkg::val_t c [3],
  input  eulbv_pkg::val_t s [3],
  output logic            out_vld,
  output eulbv_pkg::q_t   qw,
  output eulbv_pkg::q_t   qx,
  output eulbv_pkg::q_t   qy,
  output eulbv_pkg::q_t   qz
);
  import eulbv_pkg::*;

  q_t crcp, srsp, srcp, crsp, cy1, sy1;
  q_t p0, p1, p2, p3, p4, p5, p6, p7;
  logic vld1, vld2;

  always_ff @(posedge clk) begin
    if (en) begin
      crcp <= qmul(QW'(c[0]), QW'(c[1]));
      srsp <= qmul(QW'(s[0]), QW'(s[1]));
      srcp <= qmul(QW'(s[0]), QW'(c[1]));
      crsp <= qmul(QW'(c[0]), QW'(s[1]));
      cy1 <= QW'(c[2]);
      sy1 <= QW'(s[2]);
      p0 <= qmul(crcp, cy1);
      p1 <= qmul(srsp, sy1);
      p2 <= qmul(srcp, cy1);
      p3 <= qmul(crsp, sy1);
      p4 <= qmul(crsp, cy1);
      p5 <= qmul(srcp, sy1);
      p6 <= qmul(crcp, sy1);
      p7 <= qmul(srsp, cy1);
      qw <= p0 + p1;
      qx <= p2 - p3;
      qy <= p4 + p5;
      qz <= p6 - p7;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1 <= in_vld;
      vld2 <= vld1;
      out_vld <= vld2;
    end
  end

endmodule

// ===== rtl/eulbv_rotate.sv =====
// ----------------------------------------------------------------------------
// eulbv_rotate
// Rotation of the unit axes by the quaternion, rounding and saturation.
// ----------------------------------------------------------------------------
module eulbv_rotate (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_vld,
  input  eulbv_pkg::q_t          qw,
  input  eulbv_pkg::q_t          qx,
  input  eulbv_pkg::q_t          qy,
  input  eulbv_pkg::q_t          qz,
  output logic                   out_vld,
  output eulbv_pkg::basis_word_t basis
);
  import eulbv_pkg::*;

  q_t xx2, yy2, zz2, xy2, xz2, yz2, wx2, wy2, wz2;
  logic vld1;
  basis_word_t basis_next;

  always_ff @(posedge clk) begin
    if (en) begin
      xx2 <= qmul(qx, qx <<< 1);
      yy2 <= qmul(qy, qy <<< 1);
      zz2 <= qmul(qz, qz <<< 1);
      xy2 <= qmul(qx, qy <<< 1);
      xz2 <= qmul(qx, qz <<< 1);
      yz2 <= qmul(qy, qz <<< 1);
      wx2 <= qmul(qw, qx <<< 1);
      wy2 <= qmul(qw, qy <<< 1);
      wz2 <= qmul(qw, qz <<< 1);
    end
  end

  always_comb begin
    basis_next.forward_x = to_out(xz2 + wy2);
    basis_next.forward_y = to_out(yz2 - wx2);
    basis_next.forward_z = to_out(ONE_Q30 - (xx2 + yy2));
    basis_next.up_x = to_out(xy2 - wz2);
    basis_next.up_y = to_out(ONE_Q30 - (xx2 + zz2));
    basis_next.up_z = to_out(yz2 + wx2);
    basis_next.right_x = to_out(ONE_Q30 - (yy2 + zz2));
    basis_next.right_y = to_out(xy2 + wz2);
    basis_next.right_z = to_out(xz2 - wy2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      basis <= basis_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1 <= in_vld;
      out_vld <= vld1;
    end
  end

endmodule

// ===== rtl/euler_to_basis_vectors.sv =====
// ----------------------------------------------------------------------------
// euler_to_basis_vectors
// Roll, pitch and yaw in degrees to forward, up and right unit vectors.
// ----------------------------------------------------------------------------
// One word enters per cycle while the output is not stalled. The pipeline has
// one register per CORDIC iteration plus angle reduction, the sign stage,
// three quaternion stages, the axis product stage and the output register.
// The whole pipeline holds while a finished word is stalled at the output.
module euler_to_basis_vectors #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   angle_valid,
  output logic                   angle_stall,
  input  eulbv_pkg::angle_word_t angles,
  output logic                   basis_valid,
  input  logic                   basis_stall,
  output eulbv_pkg::basis_word_t basis
);
  import eulbv_pkg::*;

  logic en;
  logic red_vld;
  val_t z [3];
  logic flip [3];
  logic cor_vld [3];
  val_t c [3];
  val_t s [3];
  logic q_vld;
  q_t qw, qx, qy, qz;

  assign en = !(basis_valid && basis_stall);
  assign angle_stall = !en;

  eulbv_reduce u_reduce (
    .clk(clk), .rst(rst), .en(en), .in_vld(angle_valid), .angles(angles),
    .out_vld(red_vld), .z(z), .flip(flip)
  );

  for (genvar k = 0; k < 3; k++) begin : g_cordic
    eulbv_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
      .clk(clk), .rst(rst), .en(en), .in_vld(red_vld), .z_in(z[k]),
      .flip_in(flip[k]), .out_vld(cor_vld[k]), .cos_out(c[k]), .sin_out(s[k])
    );
  end

  eulbv_quat u_quat (
    .clk(clk), .rst(rst), .en(en), .in_vld(cor_vld[0] & cor_vld[1] & cor_vld[2]),
    .c(c), .s(s), .out_vld(q_vld), .qw(qw), .qx(qx), .qy(qy), .qz(qz)
  );

  eulbv_rotate u_rotate (
    .clk(clk), .rst(rst), .en(en), .in_vld(q_vld), .qw(qw), .qx(qx), .qy(qy),
    .qz(qz), .out_vld(basis_valid), .basis(basis)
  );

endmodule

// ===== rtl/eulbv_checker.sv =====
// ----------------------------------------------------------------------------
// eulbv_checker
// Port-level checks on the Euler-to-basis pipeline.
// ----------------------------------------------------------------------------
module eulbv_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   angle_valid,
  input logic                   angle_stall,
  input logic                   basis_valid,
  input logic                   basis_stall,
  input eulbv_pkg::basis_word_t basis
);
  import eulbv_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !basis_valid)
    else $error("word out of reset");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    basis_valid && basis_stall |=> basis_valid && $stable(basis))
    else $error("stalled word lost");

  a_back_press: assert property (@(posedge clk) disable iff (rst)
    angle_stall |-> basis_valid && basis_stall)
    else $error("input held without output stall");

  a_free_flow: assert property (@(posedge clk) disable iff (rst)
    !basis_stall |-> !angle_stall)
    else $error("input stalled while output free");

  logic unused_v;
  assign unused_v = angle_valid;

endmodule

bind euler_to_basis_vectors eulbv_checker u_eulbv_checker (
  .clk(clk), .rst(rst), .angle_valid(angle_valid), .angle_stall(angle_stall),
  .basis_valid(basis_valid), .basis_stall(basis_stall), .basis(basis)
);
